// File: rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: payload
// structs, command and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 7;
  localparam int LEN_W        = 7;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // source of the result value
  typedef enum logic [1:0] {
    RV_ZERO = 2'd0,
    RV_NEG1 = 2'd1,
    RV_DATA = 2'd2
  } rv_sel_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } ple_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    status_t                   status;
    logic [LEN_W-1:0]          length;
  } ple_out_t;

  // controller to datapath
  typedef struct packed {
    logic    load_req;
    logic    idx_load_ins;
    logic    idx_load_rem;
    logic    idx_dec;
    logic    idx_inc;
    logic    rd_pos;
    logic    rd_prev;
    logic    rd_next;
    logic    wr_pos;
    logic    wr_idx;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_set;
    status_t res_status;
    rv_sel_t res_sel;
    logic    load_out;
  } ple_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic pos_ok;
    logic ins_ok;
    logic full;
    logic ins_more;
    logic rem_more;
    logic out_free;
  } ple_sts_t;

endpackage

// File: rtl/core/ple_dp.sv
// ----------------------------------------------------------------------------
// ple_dp
// Datapath: entry memory, length counter, shift index, request and result
// registers, and the output register.
// ----------------------------------------------------------------------------
module ple_dp #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ple_pkg::ple_in_t  in_data,
  input  ple_pkg::ple_cmd_t cmd,
  output ple_pkg::ple_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output ple_pkg::ple_out_t out_data
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

  logic signed [ple_pkg::VALUE_W-1:0] entry_mem [CAPACITY];

  ple_pkg::cmd_t                      req_cmd_r;
  logic [ple_pkg::POS_W-1:0]          req_pos_r;
  logic signed [ple_pkg::VALUE_W-1:0] req_val_r;
  logic [CW-1:0]                      count_r;
  logic [AW-1:0]                      idx_r;
  logic signed [ple_pkg::VALUE_W-1:0] rd_data_r;
  ple_pkg::status_t                   res_status_r;
  logic signed [ple_pkg::VALUE_W-1:0] res_value_r;
  logic                               out_valid_r;
  ple_pkg::ple_out_t                  out_r;

  logic [CMPW-1:0]                    pos_e;
  logic [CMPW-1:0]                    cnt_e;
  logic [CMPW-1:0]                    idx_e;
  logic [CMPW-1:0]                    pos_m1;
  logic [AW-1:0]                      pos_addr;
  logic                               mem_we;
  logic                               mem_re;
  logic [AW-1:0]                      mem_waddr;
  logic [AW-1:0]                      mem_raddr;
  logic signed [ple_pkg::VALUE_W-1:0] mem_wdata;
  logic signed [ple_pkg::VALUE_W-1:0] res_value_nxt;

  assign pos_e    = CMPW'(req_pos_r);
  assign cnt_e    = CMPW'(count_r);
  assign idx_e    = CMPW'(idx_r);
  assign pos_m1   = pos_e - CMPW'(1);
  assign pos_addr = pos_m1[AW-1:0];

  assign sts.cmd      = req_cmd_r;
  assign sts.pos_ok   = (pos_e != '0) && (pos_e <= cnt_e);
  assign sts.ins_ok   = (pos_e != '0) && (pos_e <= cnt_e + CMPW'(1));
  assign sts.full     = (cnt_e == CMPW'(CAPACITY));
  assign sts.ins_more = (idx_e >= pos_e);
  assign sts.rem_more = ((idx_e + CMPW'(1)) < cnt_e);
  assign sts.out_free = !out_valid_r || out_ready;

  // memory port control
  assign mem_we    = cmd.wr_pos || cmd.wr_idx;
  assign mem_waddr = cmd.wr_pos ? pos_addr : idx_r;
  assign mem_wdata = cmd.wr_pos ? req_val_r : rd_data_r;
  assign mem_re    = cmd.rd_pos || cmd.rd_prev || cmd.rd_next;

  always_comb begin
    priority if (cmd.rd_pos) begin
      mem_raddr = pos_addr;
    end else if (cmd.rd_prev) begin
      mem_raddr = idx_r - AW'(1);
    end else begin
      mem_raddr = idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= entry_mem[mem_raddr];
    end
  end

  always_comb begin
    unique case (cmd.res_sel)
      ple_pkg::RV_DATA: res_value_nxt = rd_data_r;
      ple_pkg::RV_NEG1: res_value_nxt = '1;
      default:          res_value_nxt = '0;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_cmd_r <= in_data.cmd;
      req_pos_r <= in_data.position;
      req_val_r <= in_data.value;
    end
    if (cmd.idx_load_ins) begin
      idx_r <= count_r[AW-1:0];
    end else if (cmd.idx_load_rem) begin
      idx_r <= pos_addr;
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - AW'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_value_r  <= res_value_nxt;
    end
    if (cmd.load_out) begin
      out_r.read_value <= res_value_r;
      out_r.status     <= res_status_r;
      out_r.length     <= cnt_e[ple_pkg::LEN_W-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Controller: sequences request evaluation, memory reads, the one-entry-
// per-step shift of insert and remove, and the result transfer.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ple_pkg::ple_sts_t sts,
  output ple_pkg::ple_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RD_WAIT,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.res_set    = 1'b1;
        cmd.res_status = ple_pkg::ST_OK;
        cmd.res_sel    = ple_pkg::RV_ZERO;
        state_nxt      = S_DONE;
        unique case (sts.cmd)
          ple_pkg::CMD_READ: begin
            if (sts.pos_ok) begin
              cmd.res_set = 1'b0;
              cmd.rd_pos  = 1'b1;
              state_nxt   = S_RD_WAIT;
            end else begin
              cmd.res_status = ple_pkg::ST_RANGE;
              cmd.res_sel    = ple_pkg::RV_NEG1;
            end
          end
          ple_pkg::CMD_WRITE: begin
            if (sts.pos_ok) begin
              cmd.wr_pos = 1'b1;
            end else begin
              cmd.res_status = ple_pkg::ST_RANGE;
            end
          end
          ple_pkg::CMD_INSERT: begin
            priority if (!sts.ins_ok) begin
              cmd.res_status = ple_pkg::ST_RANGE;
            end else if (sts.full) begin
              cmd.res_status = ple_pkg::ST_FULL;
            end else begin
              cmd.res_set      = 1'b0;
              cmd.idx_load_ins = 1'b1;
              state_nxt        = S_INS_RD;
            end
          end
          ple_pkg::CMD_REMOVE: begin
            if (sts.pos_ok) begin
              cmd.res_set      = 1'b0;
              cmd.idx_load_rem = 1'b1;
              state_nxt        = S_REM_RD;
            end else begin
              cmd.res_status = ple_pkg::ST_RANGE;
            end
          end
          default: begin
            cmd.res_status = ple_pkg::ST_RANGE;
          end
        endcase
      end
      S_RD_WAIT: begin
        cmd.res_set    = 1'b1;
        cmd.res_status = ple_pkg::ST_OK;
        cmd.res_sel    = ple_pkg::RV_DATA;
        state_nxt      = S_DONE;
      end
      S_INS_RD: begin
        if (sts.ins_more) begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_INS_WR;
        end else begin
          cmd.wr_pos     = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = ple_pkg::ST_OK;
          cmd.res_sel    = ple_pkg::RV_ZERO;
          state_nxt      = S_DONE;
        end
      end
      S_INS_WR: begin
        cmd.wr_idx  = 1'b1;
        cmd.idx_dec = 1'b1;
        state_nxt   = S_INS_RD;
      end
      S_REM_RD: begin
        if (sts.rem_more) begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_REM_WR;
        end else begin
          cmd.cnt_dec    = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = ple_pkg::ST_OK;
          cmd.res_sel    = ple_pkg::RV_ZERO;
          state_nxt      = S_DONE;
        end
      end
      S_REM_WR: begin
        cmd.wr_idx  = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_REM_RD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/positional_list_engine.sv
// accept to result valid: overwrite and failed requests go from evaluation to the result;
// read adds a memory read; insert and remove add an entry shift from the position to the end.
// one request in flight; the next is taken the cycle after its result is registered.
// each shifted entry is read and then written back on the entry memory.
// synchronous active-low reset clears length, controller state and output valid;
// entry memory is not cleared.
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values with read, overwrite, insert and
// remove at one-based positions; one result per request.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ple_pkg::ple_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ple_pkg::ple_out_t out_data
);

  ple_pkg::ple_cmd_t cmd;
  ple_pkg::ple_sts_t sts;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ple_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in progress");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ple_pkg::ST_FULL) |->
      (out_data.length == CAPACITY[ple_pkg::LEN_W-1:0]))
    else $error("list full reported below capacity");

  a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ple_pkg::ST_OK) |->
      (out_data.read_value == 32'sd0 || out_data.read_value == -32'sd1))
    else $error("failed request carries data");

  a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_pos || cmd.wr_idx) |-> !in_ready)
    else $error("memory write while idle");
`endif

endmodule
